// File: hdl/mbbs_pkg.sv
// shared types and constants for the bitmap blit / braille scanout block
// no dependencies
package mbbs_pkg;

  localparam int DEF_MAX_FRAME_WIDTH   = 256;
  localparam int DEF_MAX_FRAME_HEIGHT  = 128;
  localparam int DEF_MAX_SPRITE_WIDTH  = 32;
  localparam int DEF_MAX_SPRITE_HEIGHT = 32;

  localparam int COORD_W = 12;
  localparam int ADDR_W  = 12;
  localparam int CFG_W   = 9;
  localparam int CFG_IW  = 2;

  localparam logic [1:0] FUNC_WR_FRAME  = 2'd0;
  localparam logic [1:0] FUNC_WR_SPRITE = 2'd1;
  localparam logic [1:0] FUNC_DRAW      = 2'd2;
  localparam logic [1:0] FUNC_READ_CELL = 2'd3;

  localparam logic [CFG_IW-1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [CFG_IW-1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [CFG_IW-1:0] REG_SPRITE_WIDTH  = 2'd2;
  localparam logic [CFG_IW-1:0] REG_SPRITE_HEIGHT = 2'd3;

  localparam logic [8:0] RST_FRAME_WIDTH   = 9'd256;
  localparam logic [7:0] RST_FRAME_HEIGHT  = 8'd128;
  localparam logic [5:0] RST_SPRITE_WIDTH  = 6'd32;
  localparam logic [5:0] RST_SPRITE_HEIGHT = 6'd32;

  localparam logic [7:0] UTF8_LEAD = 8'hE2;
  localparam logic [5:0] UTF8_MID  = 6'b101000;
  localparam logic [1:0] UTF8_CONT = 2'b10;

  typedef struct packed {
    logic [1:0]                func;
    logic [ADDR_W-1:0]         addr;
    logic [7:0]                data;
    logic                      skip;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] x0;
    logic signed [COORD_W-1:0] y0;
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
    logic [COORD_W-1:0]        fw;
    logic [COORD_W-1:0]        sw;
  } cmd_t;

  // dot position of pixel (dx, dy) inside a braille cell
  function automatic logic [2:0] dot_pos(input logic dx, input logic [1:0] dy);
    logic [2:0] p;
    if (dy == 2'd3) begin
      p = dx ? 3'd7 : 3'd6;
    end else begin
      p = dx ? (3'd3 + {1'b0, dy}) : {1'b0, dy};
    end
    return p;
  endfunction

  function automatic logic [23:0] utf8_of(input logic [7:0] p);
    return {UTF8_CONT, p[5:0], UTF8_MID, p[7:6], UTF8_LEAD};
  endfunction

endpackage

// File: hdl/mbbs_front.sv
// front end: config registers, size clamping and word classification
// depends on mbbs_pkg
module mbbs_front #(
  parameter int MAX_FRAME_WIDTH   = mbbs_pkg::DEF_MAX_FRAME_WIDTH,
  parameter int MAX_FRAME_HEIGHT  = mbbs_pkg::DEF_MAX_FRAME_HEIGHT,
  parameter int MAX_SPRITE_WIDTH  = mbbs_pkg::DEF_MAX_SPRITE_WIDTH,
  parameter int MAX_SPRITE_HEIGHT = mbbs_pkg::DEF_MAX_SPRITE_HEIGHT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [mbbs_pkg::CFG_IW-1:0]       cfg_index,
  input  logic [mbbs_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic [1:0]                        in_func,
  input  logic [mbbs_pkg::ADDR_W-1:0]       in_byte_address,
  input  logic [7:0]                        in_byte_value,
  input  logic signed [9:0]                 in_pos_x,
  input  logic signed [9:0]                 in_pos_y,
  input  logic [6:0]                        in_cell_col,
  input  logic [4:0]                        in_cell_row,
  output mbbs_pkg::cmd_t                    cmd
);

  localparam int CW = mbbs_pkg::COORD_W;

  logic [8:0] frame_width_r;
  logic [7:0] frame_height_r;
  logic [5:0] sprite_width_r;
  logic [5:0] sprite_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r   <= mbbs_pkg::RST_FRAME_WIDTH;
      frame_height_r  <= mbbs_pkg::RST_FRAME_HEIGHT;
      sprite_width_r  <= mbbs_pkg::RST_SPRITE_WIDTH;
      sprite_height_r <= mbbs_pkg::RST_SPRITE_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mbbs_pkg::REG_FRAME_WIDTH:   frame_width_r   <= cfg_wdata;
        mbbs_pkg::REG_FRAME_HEIGHT:  frame_height_r  <= cfg_wdata[7:0];
        mbbs_pkg::REG_SPRITE_WIDTH:  sprite_width_r  <= cfg_wdata[5:0];
        mbbs_pkg::REG_SPRITE_HEIGHT: sprite_height_r <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  logic [CW-1:0] fw_raw, fh_raw, sw_raw, sh_raw;
  logic [CW-1:0] fw, fh, sw, sh;
  logic signed [CW-1:0] px, py, pxe, pye, cx, cy;
  logic signed [CW-1:0] x0, y0, x1, y1;
  logic outside, empty;

  always_comb begin
    fw_raw = CW'(frame_width_r);
    fh_raw = CW'(frame_height_r);
    sw_raw = CW'(sprite_width_r);
    sh_raw = CW'(sprite_height_r);
    fw = (fw_raw < CW'(2)) ? CW'(2) :
         (fw_raw > CW'(MAX_FRAME_WIDTH)) ? CW'(MAX_FRAME_WIDTH) : fw_raw;
    fh = (fh_raw < CW'(4)) ? CW'(4) :
         (fh_raw > CW'(MAX_FRAME_HEIGHT)) ? CW'(MAX_FRAME_HEIGHT) : fh_raw;
    sw = (sw_raw < CW'(1)) ? CW'(1) :
         (sw_raw > CW'(MAX_SPRITE_WIDTH)) ? CW'(MAX_SPRITE_WIDTH) : sw_raw;
    sh = (sh_raw < CW'(1)) ? CW'(1) :
         (sh_raw > CW'(MAX_SPRITE_HEIGHT)) ? CW'(MAX_SPRITE_HEIGHT) : sh_raw;

    px  = CW'(in_pos_x);
    py  = CW'(in_pos_y);
    pxe = px + $signed(sw);
    pye = py + $signed(sh);
    cx  = $signed(CW'({in_cell_col, 1'b0}));
    cy  = $signed(CW'({in_cell_row, 2'b00}));

    x0 = (px < 0) ? '0 : px;
    y0 = (py < 0) ? '0 : py;
    x1 = (pxe > $signed(fw)) ? $signed(fw) : pxe;
    y1 = (pye > $signed(fh)) ? $signed(fh) : pye;
    empty   = (x0 >= x1) || (y0 >= y1);
    outside = (cx + 1 >= $signed(fw)) || (cy + 3 >= $signed(fh));

    cmd.func = in_func;
    cmd.addr = in_byte_address;
    cmd.data = in_byte_value;
    cmd.px   = px;
    cmd.py   = py;
    cmd.fw   = fw;
    cmd.sw   = sw;
    if (in_func == mbbs_pkg::FUNC_READ_CELL) begin
      cmd.skip = outside;
      cmd.x0   = cx;
      cmd.y0   = cy;
      cmd.x1   = cx;
      cmd.y1   = cy;
    end else begin
      cmd.skip = empty;
      cmd.x0   = x0;
      cmd.y0   = y0;
      cmd.x1   = x1;
      cmd.y1   = y1;
    end
  end

endmodule

// File: hdl/mbbs_queue.sv
// two-entry command queue between front and back end
// depends on mbbs_pkg
module mbbs_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mbbs_pkg::cmd_t push_cmd,
  input  logic           pop,
  output mbbs_pkg::cmd_t head,
  output logic           full,
  output logic           not_empty
);

  mbbs_pkg::cmd_t ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  assign head      = ent_r[rp_r];
  assign full      = cnt_r == 2'd2;
  assign not_empty = cnt_r != 2'd0;

endmodule

// File: hdl/mbbs_back.sv
// back end: frame and sprite stores, draw walker, cell reader, result register
// depends on mbbs_pkg
module mbbs_back #(
  parameter int MAX_FRAME_WIDTH   = mbbs_pkg::DEF_MAX_FRAME_WIDTH,
  parameter int MAX_FRAME_HEIGHT  = mbbs_pkg::DEF_MAX_FRAME_HEIGHT,
  parameter int MAX_SPRITE_WIDTH  = mbbs_pkg::DEF_MAX_SPRITE_WIDTH,
  parameter int MAX_SPRITE_HEIGHT = mbbs_pkg::DEF_MAX_SPRITE_HEIGHT
) (
  input  logic           clk,
  input  logic           rst_n,
  input  mbbs_pkg::cmd_t head,
  input  logic           not_empty,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_dots,
  output logic [23:0]    out_utf8_code,
  output logic           out_status
);

  localparam int CW           = mbbs_pkg::COORD_W;
  localparam int FRAME_BYTES  = (MAX_FRAME_WIDTH * MAX_FRAME_HEIGHT + 7) / 8;
  localparam int SPRITE_BYTES = (MAX_SPRITE_WIDTH * MAX_SPRITE_HEIGHT + 7) / 8;
  localparam int FB_AW  = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int SB_AW  = (SPRITE_BYTES > 1) ? $clog2(SPRITE_BYTES) : 1;
  localparam int FIDX_W = FB_AW + 3;
  localparam int SIDX_W = SB_AW + 3;

  typedef enum logic [2:0] {
    S_IDLE, S_SETUP, S_DRD, S_DWR, S_CRD, S_CCAP, S_DONE
  } state_t;

  state_t               state_r;
  mbbs_pkg::cmd_t       cmd_r;
  logic signed [CW-1:0] x_r, y_r;
  logic [FIDX_W-1:0]    frow_r, fidx_r;
  logic [SIDX_W-1:0]    srow_r, sidx_r;
  logic [2:0]           cnt_r;
  logic [7:0]           dots_r;
  logic                 status_r, cell_ok_r;
  logic                 out_valid_r;
  logic [7:0]           out_dots_r;
  logic [23:0]          out_utf8_r;
  logic                 out_status_r;

  logic [7:0] fmem [FRAME_BYTES];
  logic [7:0] smem [SPRITE_BYTES];
  logic [7:0] f_q_r, s_q_r;

  logic              f_we, s_we;
  logic [FB_AW-1:0]  f_wa, f_ra;
  logic [SB_AW-1:0]  s_wa, s_ra;
  logic [7:0]        f_wd, s_wd, draw_byte;
  logic [FIDX_W-1:0] cidx;
  logic              out_free, wr_frame_ok, wr_sprite_ok;

  always_comb begin
    out_free     = !out_valid_r || !out_stall;
    pop          = (state_r == S_IDLE) && not_empty;
    wr_frame_ok  = int'(head.addr) < FRAME_BYTES;
    wr_sprite_ok = int'(head.addr) < SPRITE_BYTES;
    cidx         = frow_r + FIDX_W'(cnt_r[0]);

    draw_byte = f_q_r;
    draw_byte[fidx_r[2:0]] = s_q_r[sidx_r[2:0]];

    f_we = 1'b0;
    f_wa = FB_AW'(head.addr);
    f_wd = head.data;
    s_we = pop && (head.func == mbbs_pkg::FUNC_WR_SPRITE) && wr_sprite_ok;
    s_wa = SB_AW'(head.addr);
    s_wd = head.data;
    s_ra = sidx_r[SIDX_W-1:3];
    f_ra = fidx_r[FIDX_W-1:3];
    if (state_r == S_DWR) begin
      f_we = 1'b1;
      f_wa = fidx_r[FIDX_W-1:3];
      f_wd = draw_byte;
    end else if (pop && (head.func == mbbs_pkg::FUNC_WR_FRAME) && wr_frame_ok) begin
      f_we = 1'b1;
    end
    if (state_r == S_CRD) begin
      f_ra = cidx[FIDX_W-1:3];
    end
  end

  always_ff @(posedge clk) begin
    if (f_we) fmem[f_wa] <= f_wd;
    f_q_r <= fmem[f_ra];
  end

  always_ff @(posedge clk) begin
    if (s_we) smem[s_wa] <= s_wd;
    s_q_r <= smem[s_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != S_DONE)) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (not_empty) begin
            cmd_r     <= head;
            dots_r    <= '0;
            cnt_r     <= '0;
            status_r  <= 1'b0;
            cell_ok_r <= 1'b0;
            unique case (head.func)
              mbbs_pkg::FUNC_DRAW:      state_r <= head.skip ? S_DONE : S_SETUP;
              mbbs_pkg::FUNC_READ_CELL: begin
                status_r  <= head.skip;
                cell_ok_r <= !head.skip;
                state_r   <= head.skip ? S_DONE : S_SETUP;
              end
              default:                  state_r <= S_DONE;
            endcase
          end
        end
        S_SETUP: begin
          frow_r <= FIDX_W'($unsigned(cmd_r.y0)) * FIDX_W'(cmd_r.fw)
                  + FIDX_W'($unsigned(cmd_r.x0));
          srow_r <= SIDX_W'($unsigned(cmd_r.y0 - cmd_r.py)) * SIDX_W'(cmd_r.sw)
                  + SIDX_W'($unsigned(cmd_r.x0 - cmd_r.px));
          fidx_r <= FIDX_W'($unsigned(cmd_r.y0)) * FIDX_W'(cmd_r.fw)
                  + FIDX_W'($unsigned(cmd_r.x0));
          sidx_r <= SIDX_W'($unsigned(cmd_r.y0 - cmd_r.py)) * SIDX_W'(cmd_r.sw)
                  + SIDX_W'($unsigned(cmd_r.x0 - cmd_r.px));
          x_r    <= cmd_r.x0;
          y_r    <= cmd_r.y0;
          state_r <= (cmd_r.func == mbbs_pkg::FUNC_DRAW) ? S_DRD : S_CRD;
        end
        S_DRD: state_r <= S_DWR;
        S_DWR: begin
          if (x_r + 1 < cmd_r.x1) begin
            x_r     <= x_r + CW'(1);
            fidx_r  <= fidx_r + FIDX_W'(1);
            sidx_r  <= sidx_r + SIDX_W'(1);
            state_r <= S_DRD;
          end else if (y_r + 1 < cmd_r.y1) begin
            y_r     <= y_r + CW'(1);
            x_r     <= cmd_r.x0;
            frow_r  <= frow_r + FIDX_W'(cmd_r.fw);
            srow_r  <= srow_r + SIDX_W'(cmd_r.sw);
            fidx_r  <= frow_r + FIDX_W'(cmd_r.fw);
            sidx_r  <= srow_r + SIDX_W'(cmd_r.sw);
            state_r <= S_DRD;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_CRD: state_r <= S_CCAP;
        S_CCAP: begin
          dots_r[mbbs_pkg::dot_pos(cnt_r[0], cnt_r[2:1])] <= f_q_r[cidx[2:0]];
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r[0]) frow_r <= frow_r + FIDX_W'(cmd_r.fw);
          state_r <= (cnt_r == 3'd7) ? S_DONE : S_CRD;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_dots_r   <= dots_r;
            out_utf8_r   <= cell_ok_r ? mbbs_pkg::utf8_of(dots_r) : '0;
            out_status_r <= status_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_dots      = out_dots_r;
  assign out_utf8_code = out_utf8_r;
  assign out_status    = out_status_r;

endmodule

// File: hdl/mono_bitmap_blit_braille_scanout_core.sv
// top level of the 1-bit bitmap blit and braille cell scanout block
// depends on mbbs_pkg, mbbs_front, mbbs_queue, mbbs_back
//
// input channel (in_valid / in_stall) takes one word per command: write a
// frame byte, write a sprite byte, draw the sprite at (pos_x, pos_y) with
// clipping, or read the 2x4 braille cell at (cell_col, cell_row).
// every word gives exactly one result word on out_valid / out_stall:
// dots, utf8_code and status (status set for a cell outside the frame).
// a front end classifies words into a two-entry queue, the back end
// executes them against simple dual-port frame and sprite memories.
// byte writes, clipped-away draws and outside cells go straight to the
// result; cell reads make eight pixel reads, each a read then a capture;
// draws do a read-modify-write per visible sprite pixel.
// cfg_we writes a size register in the same edge; write only while idle.
// reset (rst_n low, synchronous) restores default sizes and empties the
// queue and the result register; stores hold garbage until written.
// a stalled result holds; the queue keeps taking words until it is full,
// then in_stall goes high.
module mono_bitmap_blit_braille_scanout_core #(
  parameter int MAX_FRAME_WIDTH   = mbbs_pkg::DEF_MAX_FRAME_WIDTH,
  parameter int MAX_FRAME_HEIGHT  = mbbs_pkg::DEF_MAX_FRAME_HEIGHT,
  parameter int MAX_SPRITE_WIDTH  = mbbs_pkg::DEF_MAX_SPRITE_WIDTH,
  parameter int MAX_SPRITE_HEIGHT = mbbs_pkg::DEF_MAX_SPRITE_HEIGHT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [mbbs_pkg::CFG_IW-1:0] cfg_index,
  input  logic [mbbs_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_func,
  input  logic [11:0]                 in_byte_address,
  input  logic [7:0]                  in_byte_value,
  input  logic signed [9:0]           in_pos_x,
  input  logic signed [9:0]           in_pos_y,
  input  logic [6:0]                  in_cell_col,
  input  logic [4:0]                  in_cell_row,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_dots,
  output logic [23:0]                 out_utf8_code,
  output logic                        out_status
);

  mbbs_pkg::cmd_t front_cmd, head;
  logic full, not_empty, pop;

  mbbs_front #(
    .MAX_FRAME_WIDTH  (MAX_FRAME_WIDTH),
    .MAX_FRAME_HEIGHT (MAX_FRAME_HEIGHT),
    .MAX_SPRITE_WIDTH (MAX_SPRITE_WIDTH),
    .MAX_SPRITE_HEIGHT(MAX_SPRITE_HEIGHT)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_func        (in_func),
    .in_byte_address(in_byte_address),
    .in_byte_value  (in_byte_value),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_cell_col    (in_cell_col),
    .in_cell_row    (in_cell_row),
    .cmd            (front_cmd)
  );

  mbbs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_valid && !full),
    .push_cmd (front_cmd),
    .pop      (pop),
    .head     (head),
    .full     (full),
    .not_empty(not_empty)
  );

  mbbs_back #(
    .MAX_FRAME_WIDTH  (MAX_FRAME_WIDTH),
    .MAX_FRAME_HEIGHT (MAX_FRAME_HEIGHT),
    .MAX_SPRITE_WIDTH (MAX_SPRITE_WIDTH),
    .MAX_SPRITE_HEIGHT(MAX_SPRITE_HEIGHT)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (head),
    .not_empty    (not_empty),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_dots     (out_dots),
    .out_utf8_code(out_utf8_code),
    .out_status   (out_status)
  );

  assign in_stall = full;

endmodule

// File: sim/mono_bitmap_blit_braille_scanout_core_tb.sv
// testbench for mono_bitmap_blit_braille_scanout_core: byte writes, sprite draws
// with clipping and braille cell reads, checked word by word against a predictor
// depends on mbbs_pkg and the core rtl
`timescale 1ns / 1ps

module mono_bitmap_blit_braille_scanout_core_tb;

  localparam int FRAME_BYTES  = 4096;
  localparam int SPRITE_BYTES = 128;
  localparam logic [7:0] LEAD_BYTE = 8'hE2;
  localparam logic [7:0] MID_BASE  = 8'hA0;
  localparam logic [7:0] CONT_BASE = 8'h80;

  typedef struct {
    logic [1:0]        func;
    logic [11:0]       addr;
    logic [7:0]        value;
    logic signed [9:0] px;
    logic signed [9:0] py;
    logic [6:0]        col;
    logic [4:0]        row;
  } blit_cmd_t;

  typedef struct {
    logic [7:0]  dots;
    logic [23:0] utf8;
    logic        status;
  } cell_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [mbbs_pkg::CFG_IW-1:0] cfg_index = '0;
  logic [mbbs_pkg::CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_func = '0;
  logic [11:0] in_byte_address = '0;
  logic [7:0] in_byte_value = '0;
  logic signed [9:0] in_pos_x = '0;
  logic signed [9:0] in_pos_y = '0;
  logic [6:0] in_cell_col = '0;
  logic [4:0] in_cell_row = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_dots;
  logic [23:0] out_utf8_code;
  logic out_status;

  mono_bitmap_blit_braille_scanout_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_byte_address(in_byte_address), .in_byte_value(in_byte_value),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y),
    .in_cell_col(in_cell_col), .in_cell_row(in_cell_row),
    .out_valid(out_valid), .out_stall(out_stall), .out_dots(out_dots),
    .out_utf8_code(out_utf8_code), .out_status(out_status)
  );

  always #2 clk = ~clk;

  logic [7:0] frame_img [FRAME_BYTES];
  logic [7:0] sprite_img [SPRITE_BYTES];
  logic [8:0] fw_reg = mbbs_pkg::RST_FRAME_WIDTH;
  logic [7:0] fh_reg = mbbs_pkg::RST_FRAME_HEIGHT;
  logic [5:0] sw_reg = mbbs_pkg::RST_SPRITE_WIDTH;
  logic [5:0] sh_reg = mbbs_pkg::RST_SPRITE_HEIGHT;

  cell_word_t expected_words [$];
  int error_count = 0;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_cycles = 0;

  function automatic int clip(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic logic frame_bit(int fw, int x, int y);
    int idx;
    idx = x + y * fw;
    return frame_img[idx >> 3][idx & 7];
  endfunction

  function automatic cell_word_t predict_blit(blit_cmd_t c);
    cell_word_t r;
    int fw, fh, sw, sh, x0, y0, x1, y1, si, fi, cx, cy;
    logic [7:0] p;
    fw = clip(fw_reg, 2, 256);
    fh = clip(fh_reg, 4, 128);
    sw = clip(sw_reg, 1, 32);
    sh = clip(sh_reg, 1, 32);
    r = '{dots: '0, utf8: '0, status: 1'b0};
    case (c.func)
      mbbs_pkg::FUNC_WR_FRAME: frame_img[c.addr] = c.value;
      mbbs_pkg::FUNC_WR_SPRITE: if (c.addr < SPRITE_BYTES) sprite_img[c.addr[6:0]] = c.value;
      mbbs_pkg::FUNC_DRAW: begin
        x0 = c.px < 0 ? 0 : c.px;
        y0 = c.py < 0 ? 0 : c.py;
        x1 = c.px + sw > fw ? fw : c.px + sw;
        y1 = c.py + sh > fh ? fh : c.py + sh;
        for (int y = y0; y < y1; y++) begin
          for (int x = x0; x < x1; x++) begin
            si = (x - c.px) + (y - c.py) * sw;
            fi = x + y * fw;
            frame_img[fi >> 3][fi & 7] = sprite_img[si >> 3][si & 7];
          end
        end
      end
      default: begin
        cx = 2 * c.col;
        cy = 4 * c.row;
        if (cx + 1 >= fw || cy + 3 >= fh) begin
          r.status = 1'b1;
        end else begin
          p = {frame_bit(fw, cx + 1, cy + 3), frame_bit(fw, cx, cy + 3),
               frame_bit(fw, cx + 1, cy + 2), frame_bit(fw, cx + 1, cy + 1),
               frame_bit(fw, cx + 1, cy), frame_bit(fw, cx, cy + 2),
               frame_bit(fw, cx, cy + 1), frame_bit(fw, cx, cy)};
          r.dots = p;
          r.utf8 = {CONT_BASE + {2'b00, p[5:0]}, MID_BASE + {6'b0, p[7:6]}, LEAD_BYTE};
        end
      end
    endcase
    return r;
  endfunction

  task automatic send_cmd(blit_cmd_t c);
    while (!tx_quiet && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= c.func;
    in_byte_address <= c.addr;
    in_byte_value <= c.value;
    in_pos_x <= c.px;
    in_pos_y <= c.py;
    in_cell_col <= c.col;
    in_cell_row <= c.row;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    expected_words.push_back(predict_blit(c));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [mbbs_pkg::CFG_IW-1:0] idx, int value);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[mbbs_pkg::CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      mbbs_pkg::REG_FRAME_WIDTH: fw_reg = value[8:0];
      mbbs_pkg::REG_FRAME_HEIGHT: fh_reg = value[7:0];
      mbbs_pkg::REG_SPRITE_WIDTH: sw_reg = value[5:0];
      default: sh_reg = value[5:0];
    endcase
  endtask

  function automatic blit_cmd_t make_cmd(logic [1:0] f, int addr, int value, int px, int py,
                                         int col, int row);
    blit_cmd_t c;
    c.func = f;
    c.addr = addr[11:0];
    c.value = value[7:0];
    c.px = px[9:0];
    c.py = py[9:0];
    c.col = col[6:0];
    c.row = row[4:0];
    return c;
  endfunction

  function automatic blit_cmd_t random_cmd();
    int fw, fh, sw, sh, px, py, col, row, addr;
    logic [1:0] f;
    fw = clip(fw_reg, 2, 256);
    fh = clip(fh_reg, 4, 128);
    sw = clip(sw_reg, 1, 32);
    sh = clip(sh_reg, 1, 32);
    f = 2'($urandom_range(3));
    if ($urandom_range(9) < 8) begin
      px = $urandom_range(fw + sw) - sw;
      py = $urandom_range(fh + sh) - sh;
      col = $urandom_range(fw / 2);
      row = $urandom_range(fh / 4);
      addr = (f == mbbs_pkg::FUNC_WR_SPRITE) ? $urandom_range(SPRITE_BYTES - 1)
                                             : $urandom_range((fw * fh) / 8);
    end else begin
      px = $urandom_range(1023);
      py = $urandom_range(1023);
      col = $urandom_range(127);
      row = $urandom_range(31);
      addr = $urandom_range(4095);
    end
    return make_cmd(f, addr, $urandom_range(255), px, py, col, row);
  endfunction

  task automatic run_random(int n);
    repeat (n) send_cmd(random_cmd());
  endtask

  task automatic set_sizes(int fw, int fh, int sw, int sh);
    write_reg(mbbs_pkg::REG_FRAME_WIDTH, fw);
    write_reg(mbbs_pkg::REG_FRAME_HEIGHT, fh);
    write_reg(mbbs_pkg::REG_SPRITE_WIDTH, sw);
    write_reg(mbbs_pkg::REG_SPRITE_HEIGHT, sh);
  endtask

  // sprite bytes first, then the whole frame covered by tiled draws
  task automatic test_fill_stores();
    tx_quiet = 1'b1;
    for (int a = 0; a < SPRITE_BYTES; a++)
      send_cmd(make_cmd(mbbs_pkg::FUNC_WR_SPRITE, a, $urandom_range(255), 0, 0, 0, 0));
    for (int ty = 0; ty < 4; ty++)
      for (int tx = 0; tx < 8; tx++)
        send_cmd(make_cmd(mbbs_pkg::FUNC_DRAW, 0, 0, tx * 32, ty * 32, 0, 0));
    tx_quiet = 1'b0;
  endtask

  task automatic test_directed();
    send_cmd(make_cmd(mbbs_pkg::FUNC_WR_FRAME, 4095, 8'hFF, 0, 0, 0, 0));
    send_cmd(make_cmd(mbbs_pkg::FUNC_WR_FRAME, 0, 8'h00, 0, 0, 0, 0));
    send_cmd(make_cmd(mbbs_pkg::FUNC_WR_SPRITE, 4095, 8'hA5, 0, 0, 0, 0));
    send_cmd(make_cmd(mbbs_pkg::FUNC_WR_SPRITE, 127, 8'h5A, 0, 0, 0, 0));
    send_cmd(make_cmd(mbbs_pkg::FUNC_WR_SPRITE, 128, 8'hFF, 0, 0, 0, 0));
    send_cmd(make_cmd(mbbs_pkg::FUNC_DRAW, 0, 0, -512, -512, 0, 0));
    send_cmd(make_cmd(mbbs_pkg::FUNC_DRAW, 0, 0, 511, 511, 0, 0));
    send_cmd(make_cmd(mbbs_pkg::FUNC_DRAW, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(mbbs_pkg::FUNC_DRAW, 0, 0, -5, -3, 0, 0));
    send_cmd(make_cmd(mbbs_pkg::FUNC_DRAW, 0, 0, 250, 125, 0, 0));
    send_cmd(make_cmd(mbbs_pkg::FUNC_DRAW, 0, 0, -32, 10, 0, 0));
    send_cmd(make_cmd(mbbs_pkg::FUNC_READ_CELL, 4095, 255, -1, -1, 0, 0));
    send_cmd(make_cmd(mbbs_pkg::FUNC_READ_CELL, 0, 0, 0, 0, 127, 31));
    send_cmd(make_cmd(mbbs_pkg::FUNC_READ_CELL, 0, 0, 0, 0, 127, 0));
    send_cmd(make_cmd(mbbs_pkg::FUNC_READ_CELL, 0, 0, 0, 0, 0, 31));
    send_cmd(make_cmd(mbbs_pkg::FUNC_READ_CELL, 0, 0, 0, 0, 1, 1));
    send_cmd(make_cmd(mbbs_pkg::FUNC_READ_CELL, 0, 0, 0, 0, 62, 30));
  endtask

  task automatic test_size_sweep();
    set_sizes(2, 4, 1, 1);
    run_random(60);
    set_sizes(0, 0, 0, 0);
    run_random(40);
    set_sizes(511, 255, 63, 63);
    run_random(30);
    set_sizes(17, 9, 5, 3);
    run_random(80);
    set_sizes(256, 128, 32, 1);
    run_random(50);
    set_sizes(100, 64, 8, 8);
    run_random(90);
    set_sizes(256, 128, 3, 7);
    run_random(70);
  endtask

  task automatic test_backpressure();
    hold_req++;
    repeat (30) send_cmd(random_cmd());
    wait_drained();
    run_random(30);
  endtask

  task automatic test_no_idle();
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    run_random(100);
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        error_count++;
        if (error_count <= 10) $display("unexpected result word dots=%h", out_dots);
      end else begin
        cell_word_t e;
        e = expected_words.pop_front();
        if (e.dots !== out_dots || e.utf8 !== out_utf8_code || e.status !== out_status) begin
          error_count++;
          if (error_count <= 10)
            $display("mismatch: exp dots=%h utf8=%h status=%b got dots=%h utf8=%h status=%b",
                     e.dots, e.utf8, e.status, out_dots, out_utf8_code, out_status);
        end
      end
    end
  end

  // receiver side: long hold on request, otherwise random idling unless rx_quiet is set
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_cycles = 400;
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !rx_quiet && ($urandom_range(99) < 27);
    end
  end

  initial begin
    #100_000_000;
    $display("mono_bitmap_blit_braille_scanout_core_tb: done, errors");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fill_stores();
    test_directed();
    test_size_sweep();
    test_backpressure();
    test_no_idle();
    wait_drained();
    repeat (40) @(posedge clk);
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("mono_bitmap_blit_braille_scanout_core_tb: done, clean");
    end else begin
      $display("mono_bitmap_blit_braille_scanout_core_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/mbbs_pkg.sv
hdl/mbbs_front.sv
hdl/mbbs_queue.sv
hdl/mbbs_back.sv
hdl/mono_bitmap_blit_braille_scanout_core.sv
sim/mono_bitmap_blit_braille_scanout_core_tb.sv
